// File: rtl/itrt_pkg.sv
// Package for the integer to radix text unit.
// Holds the beat structs, character and base constants and the digit encoder.
// Depends on nothing; every other file of the block but itrt_ram imports it.
`timescale 1ns / 1ps

package itrt_pkg;

    // One input beat: the integer and the requested radix.
    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         base;
    } t_in_item;

    // One result beat: a single character of the text.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

    localparam logic [5:0] DECIMAL_BASE = 6'd10;
    localparam logic [5:0] MIN_BASE     = 6'd2;
    localparam logic [5:0] MAX_BASE     = 6'd36;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Entries of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Turns one digit value into its ASCII character.
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] wide;
        wide = {2'b00, d};
        if (d < DECIMAL_BASE) begin
            return CHAR_ZERO + wide;
        end
        return CHAR_A + wide - {2'b00, DECIMAL_BASE};
    endfunction

endpackage

// File: rtl/integer_to_radix_text_unit.sv
// Top level of the integer to radix text unit.
// Depends on itrt_pkg, itrt_front, itrt_queue, itrt_back and itrt_ram.
//
// Usage:
//   Input channel: an item (value, base) is taken at a rising edge where
//   start is high and busy is low. The base is clamped into 2 to 36.
//   Result channel: each character appears for one cycle with o_strobe
//   high; o_item.last marks the final character. The receiver cannot stall.
//   A front stage registers and classifies the item, a two-entry queue
//   holds pending jobs, and the back part converts one job at a time.
// Conversion:
//   Each digit is found by bit-serial division of the value by the base;
//   the digits are then read back from the digit store and emitted, most
//   significant first, after a minus sign where there is one. The back
//   part takes a new job only once it is through with the last one; busy
//   rises once the queue and front stage are full.
// Reset:
//   Synchronous, active low; clears the queue, the stage and the sequencer.
//   No clearing pass is needed.
`timescale 1ns / 1ps

module integer_to_radix_text_unit
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_item
);

    localparam int DW = VALUE_BITS + 7;

    logic          q_full;
    logic          push;
    logic [DW-1:0] front_desc;
    logic          pop;
    logic          q_valid;
    logic [DW-1:0] q_desc;

    itrt_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (front_desc)
    );

    itrt_queue #(
        .WIDTH (DW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_desc),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_desc)
    );

    itrt_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_desc    (q_desc),
        .o_pop     (pop),
        .o_strobe  (o_strobe),
        .o_item    (o_item)
    );

endmodule

// File: rtl/itrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module itrt_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/itrt_front.sv
// Front part: accepts input beats, clamps the base and forms the magnitude.
// Depends on itrt_pkg; feeds the job queue.
`timescale 1ns / 1ps

module itrt_front
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic [VALUE_BITS+6:0] o_desc
);

    logic                  r_valid;
    logic                  n_valid;
    logic [VALUE_BITS+6:0] r_desc;
    logic [VALUE_BITS+6:0] n_desc;
    logic                  accept;
    logic [63:0]           value_ext;
    logic [VALUE_BITS-1:0] word;
    logic [VALUE_BITS-1:0] mag;
    logic [5:0]            base_cl;
    logic                  minus;

    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_desc = r_desc;

    // Classification of the incoming beat.
    always_comb begin
        value_ext = {{32{i_item.value[31]}}, i_item.value};
        word      = value_ext[VALUE_BITS-1:0];
        priority if (i_item.base < MIN_BASE) begin
            base_cl = MIN_BASE;
        end else if (i_item.base > MAX_BASE) begin
            base_cl = MAX_BASE;
        end else begin
            base_cl = i_item.base;
        end
        minus = (base_cl == DECIMAL_BASE) && word[VALUE_BITS-1];
        mag   = minus ? (~word + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : word;
    end

    // Holding stage: reloads on accept, empties when the queue takes it.
    always_comb begin
        n_valid = r_valid;
        n_desc  = r_desc;
        if (accept) begin
            n_valid = 1'b1;
            n_desc  = {minus, base_cl, mag};
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_desc <= n_desc;
    end

endmodule

// File: rtl/itrt_queue.sv
// Short job queue between the front and back parts.
// Depends on itrt_pkg for its depth.
`timescale 1ns / 1ps

module itrt_queue
    import itrt_pkg::*;
#(
    parameter int WIDTH = 39
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_entry [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/itrt_back.sv
// Back part: divides by the base one bit a cycle, stores the digits and
// emits the characters most significant first. Depends on itrt_pkg, itrt_ram.
`timescale 1ns / 1ps

module itrt_back
    import itrt_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [VALUE_BITS+6:0] i_desc,
    output logic                  o_pop,
    output logic                  o_strobe,
    output t_out_item             o_item
);

    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam logic [AW-1:0] LAST_BIT = AW'(VALUE_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MINUS = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_quo, n_quo;
    logic [5:0]            r_rem, n_rem;
    logic [5:0]            r_base, n_base;
    logic                  r_minus, n_minus;
    logic [AW-1:0]         r_bit, n_bit;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [AW-1:0]         r_idx, n_idx;
    logic                  r_strobe, n_strobe;
    t_out_item             r_item, n_item;

    logic [6:0]            rem_s;
    logic                  ge;
    logic [5:0]            rem_new;
    logic [VALUE_BITS-1:0] quo_new;
    logic [CW-1:0]         cnt_inc;
    logic                  wr_en;
    logic                  rd_en;
    logic [5:0]            rd_data;

    // Digit store, least significant digit first.
    itrt_ram #(
        .WIDTH (6),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (rem_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // One restoring division step.
    always_comb begin
        rem_s   = {r_rem, r_quo[VALUE_BITS-1]};
        ge      = (rem_s >= {1'b0, r_base});
        rem_new = ge ? 6'(rem_s - {1'b0, r_base}) : rem_s[5:0];
        quo_new = {r_quo[VALUE_BITS-2:0], ge};
        cnt_inc = r_cnt + 1'b1;
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_base   = r_base;
        n_minus  = r_minus;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_item   = r_item;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        o_pop    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_quo   = i_desc[VALUE_BITS-1:0];
                    n_base  = i_desc[VALUE_BITS+5:VALUE_BITS];
                    n_minus = i_desc[VALUE_BITS+6];
                    n_rem   = '0;
                    n_bit   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = quo_new;
                n_rem = rem_new;
                n_bit = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    // Last bit of this digit: store it and decide on another.
                    wr_en = 1'b1;
                    n_cnt = cnt_inc;
                    n_rem = '0;
                    n_bit = '0;
                    if (quo_new == '0 || cnt_inc == CW'(VALUE_BITS)) begin
                        n_idx   = r_cnt[AW-1:0];
                        n_state = r_minus ? S_MINUS : S_READ;
                    end
                end
            end
            S_MINUS: begin
                n_strobe         = 1'b1;
                n_item.character = CHAR_MINUS;
                n_item.last      = 1'b0;
                n_state          = S_READ;
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_strobe         = 1'b1;
                n_item.character = digit_char(rd_data);
                n_item.last      = (r_idx == '0);
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
            r_quo    <= '0;
            r_minus  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
            r_quo    <= n_quo;
            r_minus  <= n_minus;
        end
        r_rem  <= n_rem;
        r_base <= n_base;
        r_bit  <= n_bit;
        r_idx  <= n_idx;
        r_item <= n_item;
    end

    assign o_strobe = r_strobe;
    assign o_item   = r_item;

endmodule
